// ===== src/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg - shared definitions for the cartridge bank mapper
// Field widths, register indexes, cartridge type codes and window constants.
// ----------------------------------------------------------------------------
package cbm_pkg;

	// ROM address bits kept on a hit offset
	localparam int ROM_ADDR_BITS = 20;

	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 8;
	localparam int OFF_W      = 20;
	localparam int SIZE_W     = 21;
	localparam int BANK_W     = 4;
	localparam int SREG_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 21;
	localparam int BANK_SHIFT = 14;

	localparam int OFF_KEEP = (ROM_ADDR_BITS < OFF_W) ? ROM_ADDR_BITS : OFF_W;
	localparam logic [OFF_W-1:0] OFF_MASK = OFF_W'((64'd1 << OFF_KEEP) - 64'd1);

	typedef enum logic [2:0] {
		CART_FLAT         = 3'd0,
		CART_BANKED       = 3'd1,
		CART_BANKED_LARGE = 3'd2,
		CART_BANKED_RAM   = 3'd3,
		CART_BANKED_ROM   = 3'd4,
		CART_ABSOLUTE     = 3'd5,
		CART_FIXED_SPLIT  = 3'd6,
		CART_UNUSED       = 3'd7
	} cart_type_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CART_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUND_EN  = 2'd2;

	// transaction opcodes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// sizes and fixed-split window bases (bytes)
	localparam logic [SIZE_W-1:0] SIZE_64K     = 21'd65536;
	localparam logic [SIZE_W-1:0] SPLIT_MIN    = 21'd122880;
	localparam logic [SIZE_W-1:0] SPLIT_B_4000 = 21'd106496;
	localparam logic [SIZE_W-1:0] SPLIT_B_6000 = 21'd98304;
	localparam logic [SIZE_W-1:0] SPLIT_B_8000 = 21'd122880;
	localparam logic [SIZE_W-1:0] SPLIT_B_E000 = 21'd114688;

	// bus addresses
	localparam logic [ADDR_W-1:0] A_4000     = 16'h4000;
	localparam logic [ADDR_W-1:0] A_6000     = 16'h6000;
	localparam logic [ADDR_W-1:0] A_8000     = 16'h8000;
	localparam logic [ADDR_W-1:0] A_A000     = 16'hA000;
	localparam logic [ADDR_W-1:0] A_C000     = 16'hC000;
	localparam logic [ADDR_W-1:0] A_E000     = 16'hE000;
	localparam logic [ADDR_W-1:0] A_SPLIT_SW = 16'hFF80;
	localparam logic [ADDR_W-1:0] A_SND_END  = 16'h4009;

	localparam logic [BANK_W-1:0] MAX_BANK = 4'd9;

	// ROM offset of a 16 KiB bank; small ROMs wrap the bank to two bits
	function automatic logic [SIZE_W-1:0] bank_offset(input logic [BANK_W-1:0] bank,
			input logic wrap2);
		logic [SIZE_W-1:0] b;
		b = wrap2 ? SIZE_W'(bank[1:0]) : SIZE_W'(bank);
		return b << BANK_SHIFT;
	endfunction

endpackage

// ===== src/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper - bus decoder and bank switch for cartridge ROM
// Decodes each bus transaction against the windows of the cartridge type,
// tracks the switched bank, and flags sound chip register writes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_stall   opcode, bus_address, write_data
//  out       source     out_valid / out_stall rom_hit, ram_hit, rom_offset,
//                                             sound_write, sound_reg, current_bank
//  cfg       sink       cfg_write             cfg_index, cfg_data
//
//  One transaction per clock sustained while out_stall is low; each one passes
//  the input register, then the result register. The bank register is read
//  and updated at the input register stage, so back-to-back writes and reads
//  see each other in order. in_stall rises only when the input register is
//  full and the result register is held by out_stall. Reset clears the bank
//  state, the configuration registers and both valid flags.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper import cbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [ADDR_W-1:0]     bus_address,
	input  logic [DATA_W-1:0]     write_data,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  rom_hit,
	output logic                  ram_hit,
	output logic [OFF_W-1:0]      rom_offset,
	output logic                  sound_write,
	output logic [SREG_W-1:0]     sound_reg,
	output logic [BANK_W-1:0]     current_bank
);

	// configuration
	cart_type_t         cart_q;
	logic [SIZE_W-1:0]  rom_size_q;
	logic               sound_en_q;

	// mapper state
	logic [BANK_W-1:0]  bank_q;
	logic               loaded_q;

	// input register
	logic               valid_s1;
	logic               op_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [DATA_W-1:0]  data_s1;

	// result register
	logic               valid_s2;
	logic               rom_hit_s2;
	logic               ram_hit_s2;
	logic [OFF_W-1:0]   off_s2;
	logic               snd_s2;
	logic [SREG_W-1:0]  sreg_s2;
	logic [BANK_W-1:0]  bank_s2;

	// handshake: the result register frees up when empty or being taken
	logic out_free, adv_s1, take_in;
	assign out_free = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	// ---------------------------------------------------------------- decode
	logic              small_rom, is_write;
	logic [SIZE_W-1:0] lo14, lo13, fix_off, lim, off;
	logic [SIZE_W-1:0] win_off;
	logic [ADDR_W-1:0] a000_rel;
	logic              fixed_ok, map_ok, ram_sel, rd_hit;
	logic              bank_req, bank_ok, snd_hit;
	logic [BANK_W-1:0] bank_cand, bank_next;

	always_comb begin
		is_write  = (op_s1 == OP_WRITE);
		small_rom = (cart_q == CART_BANKED || cart_q == CART_BANKED_RAM ||
		             cart_q == CART_BANKED_ROM) && (rom_size_q <= SIZE_64K);
		lo14     = SIZE_W'(addr_s1[13:0]);
		lo13     = SIZE_W'(addr_s1[12:0]);
		a000_rel = addr_s1 - A_A000;
		win_off  = bank_offset(bank_q, small_rom);
		lim      = (rom_size_q > SIZE_64K) ? SIZE_64K : rom_size_q;
		fix_off  = '0;
		fixed_ok = 1'b0;
		map_ok   = 1'b0;
		ram_sel  = 1'b0;
		off      = '0;

		// read windows
		case (cart_q)
			CART_FLAT: begin
				// ROM ends at 0xFFFF; larger ROMs show their top 64 KiB
				map_ok = (lim != '0) && (SIZE_W'(addr_s1) >= SIZE_64K - lim);
				off    = SIZE_W'(addr_s1) + rom_size_q - SIZE_64K;
			end
			CART_BANKED, CART_BANKED_LARGE, CART_BANKED_RAM, CART_BANKED_ROM: begin
				if (cart_q == CART_BANKED_LARGE) begin
					fixed_ok = bank_offset(4'd8, small_rom) < rom_size_q;
					fix_off  = bank_offset(4'd8, small_rom);
				end else begin
					fixed_ok = bank_offset(4'd7, small_rom) < rom_size_q;
					fix_off  = bank_offset(4'd7, small_rom);
				end
				if (cart_q == CART_BANKED_ROM)
					fixed_ok = fixed_ok && (bank_offset(4'd6, small_rom) < rom_size_q);
				if (addr_s1 >= A_C000) begin
					map_ok = fixed_ok;
					off    = fix_off + lo14;
				end else if (addr_s1 >= A_8000) begin
					map_ok = loaded_q;
					off    = win_off + lo14;
				end else if (addr_s1 >= A_4000 && fixed_ok) begin
					// middle window: RAM, nothing, or a fixed bank
					ram_sel = (cart_q == CART_BANKED_RAM);
					map_ok  = (cart_q == CART_BANKED_LARGE || cart_q == CART_BANKED_ROM);
					off     = ((cart_q == CART_BANKED_LARGE) ? bank_offset(4'd0, small_rom)
					                                         : bank_offset(4'd6, small_rom))
					          + lo14;
				end
			end
			CART_ABSOLUTE: begin
				if (addr_s1 >= A_8000) begin
					map_ok = 1'b1;
					off    = SIZE_W'(addr_s1);
				end else if (addr_s1 >= A_4000) begin
					map_ok = 1'b1;
					off    = win_off + lo14;
				end
			end
			CART_FIXED_SPLIT: begin
				fixed_ok = rom_size_q > SPLIT_MIN;
				if (addr_s1 >= A_A000 && addr_s1 < A_E000) begin
					map_ok = fixed_ok || loaded_q;
					off    = win_off + SIZE_W'(a000_rel[13:0]);
				end else if (fixed_ok && addr_s1 >= A_4000) begin
					map_ok = 1'b1;
					if (addr_s1 < A_6000)      off = SPLIT_B_4000 + lo13;
					else if (addr_s1 < A_8000) off = SPLIT_B_6000 + lo13;
					else if (addr_s1 < A_A000) off = SPLIT_B_8000 + lo13;
					else                       off = SPLIT_B_E000 + lo13;
				end
			end
			default: begin
				map_ok = 1'b0;
			end
		endcase

		rd_hit = !is_write && map_ok && (off < rom_size_q);

		// bank select on writes
		bank_req  = 1'b0;
		bank_cand = '0;
		case (cart_q)
			CART_BANKED, CART_BANKED_RAM, CART_BANKED_ROM: begin
				bank_req  = addr_s1 >= A_8000 && addr_s1 < A_C000 &&
				            data_s1 < DATA_W'(MAX_BANK);
				bank_cand = data_s1[3:0];
			end
			CART_BANKED_LARGE: begin
				bank_req  = addr_s1 >= A_8000 && addr_s1 < A_C000 &&
				            data_s1 < DATA_W'(MAX_BANK);
				bank_cand = data_s1[3:0] + 4'd1;
			end
			CART_ABSOLUTE: begin
				bank_req  = addr_s1 == A_8000 && (data_s1 == 8'd1 || data_s1 == 8'd2);
				bank_cand = data_s1[3:0] - 4'd1;
			end
			CART_FIXED_SPLIT: begin
				bank_req  = addr_s1 >= A_SPLIT_SW;
				bank_cand = {1'b0, addr_s1[2:0]};
			end
			default: begin
				bank_req = 1'b0;
			end
		endcase
		// a bank is taken only if it starts inside the ROM
		bank_ok   = is_write && bank_req &&
		            (bank_offset(bank_cand, small_rom) < rom_size_q);
		bank_next = bank_ok ? bank_cand : bank_q;

		snd_hit = is_write && sound_en_q && addr_s1 >= A_4000 && addr_s1 < A_SND_END;
	end

	// ------------------------------------------------------- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_q     <= CART_FLAT;
			rom_size_q <= '0;
			sound_en_q <= 1'b0;
			bank_q     <= '0;
			loaded_q   <= 1'b0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_CART_TYPE: cart_q     <= cart_type_t'(cfg_data[2:0]);
					CFG_ROM_SIZE:  rom_size_q <= cfg_data[SIZE_W-1:0];
					CFG_SOUND_EN:  sound_en_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (adv_s1 && bank_ok) begin
				bank_q   <= bank_cand;
				loaded_q <= 1'b1;
			end
			if (take_in)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (out_free)
				valid_s2 <= 1'b0;
		end
	end

	// ------------------------------------------------------------ payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1   <= opcode;
			addr_s1 <= bus_address;
			data_s1 <= write_data;
		end
		if (adv_s1) begin
			rom_hit_s2 <= rd_hit;
			ram_hit_s2 <= !is_write && ram_sel;
			off_s2     <= rd_hit ? (off[OFF_W-1:0] & OFF_MASK) : '0;
			snd_s2     <= snd_hit;
			sreg_s2    <= snd_hit ? addr_s1[SREG_W-1:0] : '0;
			bank_s2    <= bank_next;
		end
	end

	assign out_valid    = valid_s2;
	assign rom_hit      = rom_hit_s2;
	assign ram_hit      = ram_hit_s2;
	assign rom_offset   = off_s2;
	assign sound_write  = snd_s2;
	assign sound_reg    = sreg_s2;
	assign current_bank = bank_s2;

endmodule

// ===== src/cbm_checker.sv =====
// ----------------------------------------------------------------------------
// cbm_checker - port-level checks for the cartridge bank mapper
// Watches the result channel for consistency between its flags and fields.
// ----------------------------------------------------------------------------
module cbm_checker import cbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  rom_hit,
	input  logic                  ram_hit,
	input  logic [OFF_W-1:0]      rom_offset,
	input  logic                  sound_write,
	input  logic [SREG_W-1:0]     sound_reg,
	input  logic [BANK_W-1:0]     current_bank
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rom_offset) && $stable(current_bank))
		else $error("result transaction changed while stalled");

	// read flags and write flags never mix in one result
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (rom_hit || ram_hit) |-> !sound_write)
		else $error("read hit and sound write in one result");

	a_rom_ram: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ram_hit |-> !rom_hit && rom_offset == '0)
		else $error("RAM hit also reports ROM");

	a_sound_reg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sound_write |-> sound_reg == '0)
		else $error("sound register index without sound write");

	a_bank_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> current_bank <= MAX_BANK)
		else $error("bank beyond largest selectable bank");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);
